// ----- hw/rtl/sdmc_pkg.sv -----
// Shared types, constants and helpers for the drive move controller.
// No dependencies.
`default_nettype none

package sdmc_pkg;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_ENC    = 3'd1,
		PH_COARSE = 3'd2,
		PH_FINE   = 3'd3,
		PH_FINAL  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		DIR_FWD   = 2'd0,
		DIR_BACK  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_RIGHT = 2'd3
	} dir_t;

	localparam logic       OP_TICK  = 1'b0;
	localparam logic       OP_START = 1'b1;

	localparam logic [6:0]  POWER_RESET  = 7'd100;
	localparam logic [16:0] SMALL_TARGET = 17'd45;
	localparam logic [14:0] SMALL_BAND   = 15'd30;
	localparam logic [1:0]  BAND_NUM     = 2'd3;
	// floor(x * 52429 / 2^18) equals floor(x / 5) for every x below 2^18
	localparam logic [15:0] RECIP_FIVE   = 16'd52429;
	localparam int          RECIP_SHIFT  = 18;

	function automatic logic [16:0] abs17(input logic signed [15:0] v);
		logic [16:0] ext;
		ext = {v[15], v};
		return v[15] ? 17'(-ext) : ext;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sync_drive_move_controller.sv -----
// Drive move controller: input register, move state update, result register.
// Depends on sdmc_pkg.
// Input beats pass the input register, then the result register.
// Throughput: one beat per cycle unless res_stall holds a result; the move
// state updates as the result register loads; the next beat sees it at once.
// Reset (arst_n low, asynchronous): phase idle, target and direction zero,
// done flags and drive levels zero, drive_power 100, both stages empty.
`default_nettype none

module sync_drive_move_controller (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_wen,
	input  wire [6:0]          cfg_wdata,
	input  wire                item_valid,
	output logic               item_stall,
	input  wire                op,
	input  wire [1:0]          direction,
	input  wire signed [15:0]  target,
	input  wire                use_gyro,
	input  wire signed [15:0]  gyro_a,
	input  wire signed [15:0]  gyro_b,
	input  wire signed [15:0]  left_count,
	input  wire signed [15:0]  right_count,
	output logic               res_valid,
	input  wire                res_stall,
	output logic signed [7:0]  left_drive,
	output logic signed [7:0]  right_drive,
	output logic               busy_res,
	output logic               finished,
	output logic               settle_pause
);
	import sdmc_pkg::*;

	logic [6:0]         drive_power_q;
	logic               valid_s1;
	logic               op_s1;
	logic [1:0]         direction_s1;
	logic signed [15:0] target_s1;
	logic               use_gyro_s1;
	logic signed [15:0] gyro_a_s1;
	logic signed [15:0] gyro_b_s1;
	logic signed [15:0] left_count_s1;
	logic signed [15:0] right_count_s1;

	phase_t             phase_q, phase_d;
	logic signed [15:0] move_target_q;
	dir_t               move_dir_q;
	logic               left_done_q, left_done_d;
	logic               right_done_q, right_done_d;
	logic signed [7:0]  left_level_q, left_level_d;
	logic signed [7:0]  right_level_q, right_level_d;
	logic               finished_d, settle_d;

	logic               out_free;
	logic               advance;

	logic [16:0]        lc_abs, rc_abs, tgt_abs;
	logic               left_run, right_run, left_back, right_back;
	logic signed [7:0]  pw, hp;
	logic signed [16:0] gsum;
	logic signed [16:0] avg;
	logic signed [18:0] avg19, tgt19, lo19, hi19;
	logic [16:0]        tri_tgt;
	logic [32:0]        band_prod;
	logic [14:0]        band;

	assign out_free   = !res_valid || !res_stall;
	assign advance    = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_power_q <= POWER_RESET;
		end else if (cfg_wen) begin
			drive_power_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			op_s1          <= op;
			direction_s1   <= direction;
			target_s1      <= target;
			use_gyro_s1    <= use_gyro;
			gyro_a_s1      <= gyro_a;
			gyro_b_s1      <= gyro_b;
			left_count_s1  <= left_count;
			right_count_s1 <= right_count;
		end
	end

	assign pw = {1'b0, drive_power_q};
	assign hp = {2'b00, drive_power_q[6:1]};

	assign lc_abs  = abs17(left_count_s1);
	assign rc_abs  = abs17(right_count_s1);
	assign tgt_abs = abs17(move_target_q);

	assign left_run  = $signed({1'b0, lc_abs}) < $signed({{2{move_target_q[15]}}, move_target_q});
	assign right_run = $signed({1'b0, rc_abs}) < $signed({{2{move_target_q[15]}}, move_target_q});
	assign left_back  = (move_dir_q == DIR_BACK) || (move_dir_q == DIR_LEFT);
	assign right_back = (move_dir_q == DIR_BACK) || (move_dir_q == DIR_RIGHT);

	assign gsum  = 17'(gyro_a_s1) + 17'(gyro_b_s1);
	assign avg   = $signed(gsum + {16'd0, gsum[16]}) >>> 1;
	assign avg19 = 19'(avg);
	assign tgt19 = 19'(move_target_q);

	assign tri_tgt   = 17'(tgt_abs * BAND_NUM);
	assign band_prod = {16'd0, tri_tgt} * {17'd0, RECIP_FIVE};
	assign band      = (tgt_abs < SMALL_TARGET) ? SMALL_BAND : band_prod[RECIP_SHIFT +: 15];
	assign lo19      = tgt19 - {4'd0, band};
	assign hi19      = tgt19 + {4'd0, band};

	always_comb begin
		phase_d       = phase_q;
		left_done_d   = left_done_q;
		right_done_d  = right_done_q;
		left_level_d  = left_level_q;
		right_level_d = right_level_q;
		finished_d    = 1'b0;
		settle_d      = 1'b0;
		if (op_s1 == OP_START) begin
			phase_d      = use_gyro_s1 ? PH_COARSE : PH_ENC;
			left_done_d  = 1'b0;
			right_done_d = 1'b0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
				end
				PH_ENC: begin
					if (left_run) begin
						left_level_d = left_back ? 8'(-pw) : pw;
					end else begin
						left_done_d  = 1'b1;
						left_level_d = '0;
					end
					if (right_run) begin
						right_level_d = right_back ? 8'(-pw) : pw;
					end else begin
						right_done_d  = 1'b1;
						right_level_d = '0;
					end
					if (left_done_d && right_done_d) begin
						left_level_d  = '0;
						right_level_d = '0;
						phase_d       = PH_IDLE;
						finished_d    = 1'b1;
					end
				end
				PH_COARSE: begin
					if (avg19 < lo19) begin
						left_level_d  = 8'(-pw);
						right_level_d = pw;
					end else if (avg19 > hi19) begin
						left_level_d  = pw;
						right_level_d = 8'(-pw);
					end else begin
						left_level_d  = '0;
						right_level_d = '0;
						settle_d      = 1'b1;
						phase_d       = PH_FINE;
					end
				end
				PH_FINE: begin
					if (avg19 < tgt19) begin
						left_level_d  = 8'(-hp);
						right_level_d = hp;
					end else if (avg19 > tgt19) begin
						left_level_d  = hp;
						right_level_d = 8'(-hp);
					end else begin
						phase_d = PH_FINAL;
					end
				end
				PH_FINAL: begin
					left_done_d   = 1'b1;
					right_done_d  = 1'b1;
					left_level_d  = '0;
					right_level_d = '0;
					phase_d       = PH_IDLE;
					finished_d    = 1'b1;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			move_target_q <= '0;
			move_dir_q    <= DIR_FWD;
			left_done_q   <= 1'b0;
			right_done_q  <= 1'b0;
			left_level_q  <= '0;
			right_level_q <= '0;
			res_valid     <= 1'b0;
			busy_res      <= 1'b0;
			finished      <= 1'b0;
			settle_pause  <= 1'b0;
		end else begin
			if (out_free) begin
				res_valid <= valid_s1;
			end
			if (advance) begin
				phase_q       <= phase_d;
				left_done_q   <= left_done_d;
				right_done_q  <= right_done_d;
				left_level_q  <= left_level_d;
				right_level_q <= right_level_d;
				busy_res      <= (phase_d != PH_IDLE);
				finished      <= finished_d;
				settle_pause  <= settle_d;
				if (op_s1 == OP_START) begin
					move_target_q <= target_s1;
					move_dir_q    <= dir_t'(direction_s1);
				end
			end
		end
	end

	assign left_drive  = left_level_q;
	assign right_drive = right_level_q;

	a_finish_stops: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && finished |-> !busy_res && left_drive == 8'sd0 && right_drive == 8'sd0)
		else $error("finish beat with drive or busy set");

	a_settle_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && settle_pause |-> busy_res && !finished && left_drive == 8'sd0
			&& right_drive == 8'sd0)
		else $error("settle beat malformed");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE && !(advance && op_s1 == OP_START) |=> phase_q == PH_IDLE)
		else $error("left idle without a start beat");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && res_valid && res_stall)
		else $error("input stalled with room downstream");

	a_busy_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		$past(advance) |-> busy_res == (phase_q != PH_IDLE))
		else $error("busy flag out of step with phase");

endmodule

`default_nettype wire

// ----- verif/sdmc_checker.sv -----
// Scoreboard for the drive move controller: watches both beat channels and the
// power register write, predicts each result beat and compares it field by field.
// Depends on sdmc_pkg.
module sdmc_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_wen,
	input  wire [6:0]         cfg_wdata,
	input  wire               item_valid,
	input  wire               item_stall,
	input  wire               op,
	input  wire [1:0]         direction,
	input  wire signed [15:0] target,
	input  wire               use_gyro,
	input  wire signed [15:0] gyro_a,
	input  wire signed [15:0] gyro_b,
	input  wire signed [15:0] left_count,
	input  wire signed [15:0] right_count,
	input  wire               res_valid,
	input  wire               res_stall,
	input  wire signed [7:0]  left_drive,
	input  wire signed [7:0]  right_drive,
	input  wire               busy_res,
	input  wire               finished,
	input  wire               settle_pause,
	output int                pending,
	output int                n_fail
);
	timeunit 1ns;
	timeprecision 1ps;
	import sdmc_pkg::*;

	typedef struct {
		logic signed [7:0] left;
		logic signed [7:0] right;
		logic              busy;
		logic              fin;
		logic              settle;
	} drive_levels_t;

	drive_levels_t     levels_q[$];
	phase_t            phase;
	dir_t              heading_dir;
	logic signed [15:0] goal;
	logic              ldone;
	logic              rdone;
	logic signed [7:0] lvl_l;
	logic signed [7:0] lvl_r;
	logic [6:0]        power;
	int                errs = 0;

	task automatic predict_levels();
		drive_levels_t r;
		int            lc;
		int            rc;
		int            avg;
		int            band;
		int            t;
		int            pw;
		int            hp;
		r.fin = 1'b0;
		r.settle = 1'b0;
		pw = int'(power);
		hp = int'(power >> 1);
		t = int'(goal);
		avg = (int'(gyro_a) + int'(gyro_b)) / 2;
		if (op == OP_START) begin
			heading_dir = dir_t'(direction);
			goal = target;
			phase = use_gyro ? PH_COARSE : PH_ENC;
			ldone = 1'b0;
			rdone = 1'b0;
		end else begin
			case (phase)
				PH_ENC: begin
					lc = (left_count < 0) ? -int'(left_count) : int'(left_count);
					rc = (right_count < 0) ? -int'(right_count) : int'(right_count);
					if (lc < t) begin
						lvl_l = (heading_dir == DIR_BACK || heading_dir == DIR_LEFT) ?
							8'(-pw) : 8'(pw);
					end else begin
						ldone = 1'b1;
						lvl_l = 8'sd0;
					end
					if (rc < t) begin
						lvl_r = (heading_dir == DIR_BACK || heading_dir == DIR_RIGHT) ?
							8'(-pw) : 8'(pw);
					end else begin
						rdone = 1'b1;
						lvl_r = 8'sd0;
					end
					if (ldone && rdone) begin
						lvl_l = 8'sd0;
						lvl_r = 8'sd0;
						phase = PH_IDLE;
						r.fin = 1'b1;
					end
				end
				PH_COARSE: begin
					band = ((t < 0 ? -t : t) < 45) ? 30 : ((t < 0 ? -t : t) * 3) / 5;
					if (avg < t - band) begin
						lvl_l = 8'(-pw);
						lvl_r = 8'(pw);
					end else if (avg > t + band) begin
						lvl_l = 8'(pw);
						lvl_r = 8'(-pw);
					end else begin
						lvl_l = 8'sd0;
						lvl_r = 8'sd0;
						r.settle = 1'b1;
						phase = PH_FINE;
					end
				end
				PH_FINE: begin
					if (avg < t) begin
						lvl_l = 8'(-hp);
						lvl_r = 8'(hp);
					end else if (avg > t) begin
						lvl_l = 8'(hp);
						lvl_r = 8'(-hp);
					end else begin
						phase = PH_FINAL;
					end
				end
				PH_FINAL: begin
					ldone = 1'b1;
					rdone = 1'b1;
					lvl_l = 8'sd0;
					lvl_r = 8'sd0;
					phase = PH_IDLE;
					r.fin = 1'b1;
				end
				default: ;
			endcase
		end
		r.left = lvl_l;
		r.right = lvl_r;
		r.busy = (phase != PH_IDLE);
		levels_q.push_back(r);
	endtask

	task automatic compare_levels();
		drive_levels_t e;
		if (levels_q.size() == 0) begin
			$error("result beat with no prediction waiting");
			errs++;
			return;
		end
		e = levels_q.pop_front();
		if (left_drive !== e.left) begin
			$error("left_drive: expected %0d, got %0d", e.left, left_drive);
			errs++;
		end
		if (right_drive !== e.right) begin
			$error("right_drive: expected %0d, got %0d", e.right, right_drive);
			errs++;
		end
		if (busy_res !== e.busy) begin
			$error("busy_res: expected %0d, got %0d", e.busy, busy_res);
			errs++;
		end
		if (finished !== e.fin) begin
			$error("finished: expected %0d, got %0d", e.fin, finished);
			errs++;
		end
		if (settle_pause !== e.settle) begin
			$error("settle_pause: expected %0d, got %0d", e.settle, settle_pause);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PH_IDLE;
			heading_dir = DIR_FWD;
			goal = '0;
			ldone = 1'b0;
			rdone = 1'b0;
			lvl_l = '0;
			lvl_r = '0;
			power = POWER_RESET;
			levels_q.delete();
			pending <= 0;
			n_fail <= errs;
		end else begin
			if (res_valid && !res_stall)
				compare_levels();
			if (item_valid && !item_stall)
				predict_levels();
			if (cfg_wen)
				power = cfg_wdata;
			pending <= levels_q.size();
			n_fail <= errs;
		end
	end

endmodule

// ----- verif/testbench.sv -----
// Top of the drive move controller bench: clock, reset, beat stimulus and verdict.
// Depends on sdmc_pkg, sync_drive_move_controller and sdmc_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sdmc_pkg::*;

	typedef struct {
		logic              op;
		logic [1:0]        dir;
		logic signed [15:0] goal;
		logic              gyro;
		logic signed [15:0] ga;
		logic signed [15:0] gb;
		logic signed [15:0] lc;
		logic signed [15:0] rc;
	} move_beat_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_wen = 1'b0;
	logic [6:0]         cfg_wdata = '0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic               op = 1'b0;
	logic [1:0]         direction = '0;
	logic signed [15:0] target = '0;
	logic               use_gyro = 1'b0;
	logic signed [15:0] gyro_a = '0;
	logic signed [15:0] gyro_b = '0;
	logic signed [15:0] left_count = '0;
	logic signed [15:0] right_count = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	logic signed [7:0]  left_drive;
	logic signed [7:0]  right_drive;
	logic               busy_res;
	logic               finished;
	logic               settle_pause;
	int                 pending;
	int                 n_fail;
	logic               calm = 1'b0;
	int                 beats_sent = 0;
	int                 quiet_cycles = 0;

	sync_drive_move_controller u_dut (.*);
	sdmc_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		res_stall <= !calm && ($urandom_range(99) < 15);

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 2000) begin
			$display("testbench: errors");
			$finish;
		end
	end

	function automatic logic signed [15:0] sat16(input int v);
		if (v > 32767)
			return 16'h7FFF;
		if (v < -32768)
			return 16'h8000;
		return 16'(v);
	endfunction

	function automatic move_beat_t noise();
		move_beat_t b;
		b.op = 1'($urandom_range(1));
		b.dir = 2'($urandom_range(3));
		b.goal = 16'($urandom);
		b.gyro = 1'($urandom_range(1));
		b.ga = 16'($urandom);
		b.gb = 16'($urandom);
		b.lc = 16'($urandom);
		b.rc = 16'($urandom);
		return b;
	endfunction

	task automatic send(input move_beat_t b);
		while (!calm && $urandom_range(99) < 15) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		op <= b.op;
		direction <= b.dir;
		target <= b.goal;
		use_gyro <= b.gyro;
		gyro_a <= b.ga;
		gyro_b <= b.gb;
		left_count <= b.lc;
		right_count <= b.rc;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic start_move(input dir_t d, input int g, input logic gy);
		move_beat_t b;
		b = noise();
		b.op = OP_START;
		b.dir = d;
		b.goal = sat16(g);
		b.gyro = gy;
		send(b);
	endtask

	task automatic tick(input int ga, input int gb, input int lc, input int rc);
		move_beat_t b;
		b = noise();
		b.op = OP_TICK;
		b.ga = sat16(ga);
		b.gb = sat16(gb);
		b.lc = sat16(lc);
		b.rc = sat16(rc);
		send(b);
	endtask

	task automatic heading(input int h);
		int s;
		s = $urandom_range(50);
		tick(h + s, h - s, int'($signed(16'($urandom))), int'($signed(16'($urandom))));
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic encoder_move();
		int goal;
		int n;
		int step;
		int l;
		int r;
		case ($urandom_range(9))
			0: goal = int'($urandom_range(65535)) - 32768;
			1: goal = -int'($urandom_range(100));
			default: goal = $urandom_range(1, 80);
		endcase
		start_move(dir_t'($urandom_range(3)), goal, 1'b0);
		n = $urandom_range(1, 10);
		step = ((goal > 0) ? goal : 8) / n + 1;
		l = 0;
		r = 0;
		repeat (n + 2) begin
			l += $urandom_range(2 * step);
			r += $urandom_range(2 * step);
			tick(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
				$urandom_range(1) ? -l : l, $urandom_range(1) ? -r : r);
		end
	endtask

	task automatic gyro_move();
		int goal;
		int mag;
		int band;
		case ($urandom_range(9))
			0, 1: goal = int'($urandom_range(65535)) - 32768;
			2: goal = $urandom_range(1) ? 32767 : -32768;
			default: goal = int'($urandom_range(400)) - 200;
		endcase
		mag = (goal < 0) ? -goal : goal;
		band = (mag < 45) ? 30 : (mag * 3) / 5;
		start_move(dir_t'($urandom_range(3)), goal, 1'b1);
		repeat ($urandom_range(3))
			heading($urandom_range(1) ? goal + band + 1 + $urandom_range(300) :
				goal - band - 1 - $urandom_range(300));
		heading(goal + int'($urandom_range(2 * band)) - band);
		repeat ($urandom_range(3))
			heading($urandom_range(1) ? goal + $urandom_range(1, 20) :
				goal - $urandom_range(1, 20));
		heading(goal);
		heading(int'($signed(16'($urandom))));
	endtask

	initial begin
		int powers[6];
		int quota;
		int k;
		powers = '{100, 127, 0, 1, 64, 0};
		powers[5] = $urandom_range(2, 126);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle ticks
		tick(32767, -32768, -32768, 32767);
		tick(-32768, 32767, 0, -1);
		// encoder moves in every direction
		start_move(DIR_FWD, 100, 1'b0);
		tick(0, 0, 10, 99);
		tick(0, 0, 200, 5);
		tick(0, 0, 3, 5);
		tick(0, 0, 3, -32768);
		start_move(DIR_BACK, 50, 1'b0);
		tick(0, 0, -49, 49);
		tick(0, 0, -32768, 32767);
		start_move(DIR_LEFT, 20, 1'b0);
		tick(0, 0, 1, 1);
		start_move(DIR_RIGHT, 20, 1'b0);
		tick(0, 0, 1, -1);
		start_move(DIR_FWD, 0, 1'b0);
		tick(0, 0, 0, 0);
		start_move(DIR_FWD, -32768, 1'b0);
		tick(0, 0, 5, 5);
		// heading turns through coarse, fine and final stages
		start_move(DIR_LEFT, 0, 1'b1);
		tick(-32768, -32768, 0, 0);
		tick(32767, 32767, 0, 0);
		tick(-3, 0, 0, 0);
		tick(-3, 0, 0, 0);
		tick(5, 4, 0, 0);
		tick(1, -1, 0, 0);
		tick(7, 7, 0, 0);
		start_move(DIR_RIGHT, 32767, 1'b1);
		tick(0, 0, 0, 0);
		tick(32767, 13107, 0, 0);
		start_move(DIR_RIGHT, -32768, 1'b1);
		tick(-32768, -32768, 0, 0);
		tick(-32768, -32768, 0, 0);
		tick(0, 0, 0, 0);
		start_move(DIR_FWD, 44, 1'b1);
		tick(14, 14, 0, 0);

		for (int p = 0; p < 6; p++) begin
			if (p > 0) begin
				drain();
				cfg_wen <= 1'b1;
				cfg_wdata <= 7'(powers[p]);
				@(posedge clk);
				cfg_wen <= 1'b0;
			end
			calm <= (p == 2);
			quota = beats_sent + 300;
			while (beats_sent < quota) begin
				k = $urandom_range(9);
				if (k == 0)
					repeat (5) send(noise());
				else if (k < 5)
					encoder_move();
				else
					gyro_move();
			end
		end

		drain();
		repeat (4) @(posedge clk);
		if (n_fail == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
